### hw/rtl/brb_pkg.sv
// brb_pkg: shared constants, operation codes and the result descriptor
// for the byte ring buffer. Used by brb_mem, brb_ctrl, byte_ring_buffer and tb_top.
// No dependencies.
package brb_pkg;

	// default number of slots in the store
	localparam int unsigned DEPTH_DEFAULT = 1024;

	// size register value after reset, clamped to the store depth in the control
	localparam int unsigned SIZE_RESET = 1024;
	localparam int unsigned SIZE_MIN   = 2;

	// fixed field widths
	localparam int unsigned MODE_W = 3;
	localparam int unsigned DATA_W = 8;
	localparam int unsigned OFS_W  = 10;
	localparam int unsigned CFG_W  = 11;
	localparam int unsigned CNT_W  = 10;

	// operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH      = 3'd0,
		MODE_POP       = 3'd1,
		MODE_PEEK      = 3'd2,
		MODE_ADVANCE   = 3'd3,
		MODE_OVERWRITE = 3'd4,
		MODE_CLEAR     = 3'd5
	} mode_t;

	// per-item status from the control to the result pipeline
	typedef struct packed {
		logic             has_data;
		logic             accepted;
		logic [CNT_W-1:0] fill_count;
		logic [CNT_W-1:0] free_count;
	} result_t;

endpackage

### hw/rtl/brb_mem.sv
// brb_mem: byte store of the ring buffer, one write port and one read
// port with registered read data. Depends on brb_pkg for the data width.
module brb_mem #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [brb_pkg::DATA_W-1:0]  wdata,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [brb_pkg::DATA_W-1:0]  rdata
);

	logic [brb_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [brb_pkg::DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/brb_ctrl.sv
// brb_ctrl: pointers, fill count and size register of the ring buffer;
// decides each operation and drives the byte store ports.
// Depends on brb_pkg.
module brb_ctrl #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_acc,
	input  logic [brb_pkg::MODE_W-1:0]  mode,
	input  logic [brb_pkg::DATA_W-1:0]  data_in,
	input  logic [brb_pkg::OFS_W-1:0]   offset,
	input  logic                        cfg_we,
	input  logic [brb_pkg::CFG_W-1:0]   cfg_size,
	output logic                        mem_we,
	output logic [$clog2(DEPTH)-1:0]    mem_waddr,
	output logic [brb_pkg::DATA_W-1:0]  mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(DEPTH)-1:0]    mem_raddr,
	output brb_pkg::result_t            res
);

	localparam int unsigned PTR_W  = $clog2(DEPTH);
	localparam int unsigned SIZE_W = $clog2(DEPTH + 1);
	localparam int unsigned W      = ((PTR_W > brb_pkg::OFS_W) ? PTR_W : brb_pkg::OFS_W) + 1;
	localparam int unsigned CW     = ((SIZE_W > brb_pkg::CFG_W) ? SIZE_W : brb_pkg::CFG_W) + 1;
	localparam int unsigned RESET_SIZE =
		(brb_pkg::SIZE_RESET > DEPTH) ? DEPTH : brb_pkg::SIZE_RESET;

	logic [PTR_W-1:0]  rp_q, wp_q, fill_q;
	logic [SIZE_W-1:0] size_q;

	logic [PTR_W-1:0]  rp_d, wp_d, fill_d;
	logic [W-1:0]      size_w, fill_w, ofs_w, sum_w, rp_inc_w, wp_inc_w, free_w;
	logic [PTR_W-1:0]  off_ptr, rp_inc, wp_inc;
	logic              push_ok, pop_ok, peek_ok, adv_ok, ok, has_data;
	logic [CW-1:0]     cfg_c;
	logic [SIZE_W-1:0] size_clamped;

	// operands at a common width
	assign size_w = W'(size_q);
	assign fill_w = W'(fill_q);
	assign ofs_w  = W'(offset);

	// range checks
	assign push_ok = fill_w < (size_w - W'(1));
	assign pop_ok  = fill_q != '0;
	assign peek_ok = ofs_w < fill_w;
	assign adv_ok  = ofs_w <= fill_w;

	// head plus offset, wrapped once
	assign sum_w   = W'(rp_q) + ofs_w;
	assign off_ptr = (sum_w >= size_w) ? PTR_W'(sum_w - size_w) : PTR_W'(sum_w);

	// pointer increments with wrap
	assign rp_inc_w = W'(rp_q) + W'(1);
	assign wp_inc_w = W'(wp_q) + W'(1);
	assign rp_inc   = (rp_inc_w == size_w) ? '0 : PTR_W'(rp_inc_w);
	assign wp_inc   = (wp_inc_w == size_w) ? '0 : PTR_W'(wp_inc_w);

	// operation decode
	always_comb begin
		rp_d      = rp_q;
		wp_d      = wp_q;
		fill_d    = fill_q;
		ok        = 1'b0;
		has_data  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_re    = 1'b0;
		mem_raddr = rp_q;
		case (brb_pkg::mode_t'(mode))
			brb_pkg::MODE_PUSH: begin
				if (push_ok) begin
					mem_we = item_acc;
					wp_d   = wp_inc;
					fill_d = fill_q + PTR_W'(1);
					ok     = 1'b1;
				end
			end
			brb_pkg::MODE_POP: begin
				if (pop_ok) begin
					mem_re   = item_acc;
					rp_d     = rp_inc;
					fill_d   = fill_q - PTR_W'(1);
					ok       = 1'b1;
					has_data = 1'b1;
				end
			end
			brb_pkg::MODE_PEEK: begin
				if (peek_ok) begin
					mem_re    = item_acc;
					mem_raddr = off_ptr;
					ok        = 1'b1;
					has_data  = 1'b1;
				end
			end
			brb_pkg::MODE_ADVANCE: begin
				if (adv_ok) begin
					rp_d   = off_ptr;
					fill_d = PTR_W'(fill_w - ofs_w);
					ok     = 1'b1;
				end
			end
			brb_pkg::MODE_OVERWRITE: begin
				if (peek_ok) begin
					mem_we    = item_acc;
					mem_waddr = off_ptr;
					ok        = 1'b1;
				end
			end
			brb_pkg::MODE_CLEAR: begin
				rp_d   = '0;
				wp_d   = '0;
				fill_d = '0;
				ok     = 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign mem_wdata = data_in;

	// counts after the operation
	assign free_w = size_w - W'(1) - W'(fill_d);

	always_comb begin
		res.has_data   = has_data;
		res.accepted   = ok;
		res.fill_count = brb_pkg::CNT_W'(fill_d);
		res.free_count = brb_pkg::CNT_W'(free_w);
	end

	// size clamp for configuration writes
	assign cfg_c = CW'(cfg_size);
	always_comb begin
		if (cfg_c < CW'(brb_pkg::SIZE_MIN)) begin
			size_clamped = SIZE_W'(brb_pkg::SIZE_MIN);
		end else if (cfg_c > CW'(DEPTH)) begin
			size_clamped = SIZE_W'(DEPTH);
		end else begin
			size_clamped = SIZE_W'(cfg_c);
		end
	end

	// pointer, fill and size state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			size_q <= SIZE_W'(RESET_SIZE);
		end else if (cfg_we) begin
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			size_q <= size_clamped;
		end else if (item_acc) begin
			rp_q   <= rp_d;
			wp_q   <= wp_d;
			fill_q <= fill_d;
		end
	end

	// fill stays below the slot count
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		W'(fill_q) < W'(size_q))
		else $error("fill count reached the slot count");

	// pointers stay inside the active slots
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(W'(rp_q) < W'(size_q)) && (W'(wp_q) < W'(size_q)))
		else $error("pointer outside the active slots");

	// fill count agrees with the pointer distance
	a_fill_match: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q >= rp_q) ? (fill_q == PTR_W'(wp_q - rp_q))
		               : (W'(fill_q) == W'(size_q) - W'(rp_q) + W'(wp_q)))
		else $error("fill count differs from pointer distance");

	// a configuration write leaves the buffer empty
	a_cfg_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (fill_q == '0) && (rp_q == '0) && (wp_q == '0))
		else $error("buffer not empty after size write");

endmodule

### hw/rtl/byte_ring_buffer.sv
// byte_ring_buffer: byte FIFO in a circular store of configurable size.
// An accepted transaction's result passes stage 1, then the output register.
// Throughput: one transaction per cycle unless in_stall holds the input; the
// store takes one read and one write per cycle and pointers update in the accepting cycle.
// Reset: pointers and fill clear, size goes to 1024 slots (or DEPTH).
// Depends on brb_pkg, brb_ctrl and brb_mem.
module byte_ring_buffer #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [brb_pkg::CFG_W-1:0]   buffer_size,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [brb_pkg::MODE_W-1:0]  mode,
	input  logic [brb_pkg::DATA_W-1:0]  data_in,
	input  logic [brb_pkg::OFS_W-1:0]   offset,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [brb_pkg::DATA_W-1:0]  read_data,
	output logic                        accepted,
	output logic [brb_pkg::CNT_W-1:0]   fill_count,
	output logic [brb_pkg::CNT_W-1:0]   free_count
);

	localparam int unsigned PTR_W = $clog2(DEPTH);

	logic                       item_acc, out_free, cfg_we;
	logic                       mem_we, mem_re;
	logic [PTR_W-1:0]           mem_waddr, mem_raddr;
	logic [brb_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
	brb_pkg::result_t           res;

	logic                       valid_s1;
	brb_pkg::result_t           res_s1;
	logic                       out_valid_q;
	logic [brb_pkg::DATA_W-1:0] read_data_q;
	logic                       accepted_q;
	logic [brb_pkg::CNT_W-1:0]  fill_count_q, free_count_q;

	// handshakes
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !out_free;
	assign item_acc  = in_valid && !in_stall;
	assign cfg_ready = !valid_s1 && !out_valid_q && !in_valid;
	assign cfg_we    = cfg_valid && cfg_ready;

	brb_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_acc  (item_acc),
		.mode      (mode),
		.data_in   (data_in),
		.offset    (offset),
		.cfg_we    (cfg_we),
		.cfg_size  (buffer_size),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res)
	);

	brb_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// stage 1: wait for the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			res_s1 <= res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			read_data_q  <= res_s1.has_data ? mem_rdata : '0;
			accepted_q   <= res_s1.accepted;
			fill_count_q <= res_s1.fill_count;
			free_count_q <= res_s1.free_count;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign accepted   = accepted_q;
	assign fill_count = fill_count_q;
	assign free_count = free_count_q;

	// a held stage 1 item blocks new transactions
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |-> !item_acc)
		else $error("transaction accepted over a held item");

	// an accepted transaction reaches stage 1
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> valid_s1)
		else $error("accepted transaction lost before stage 1");

	// no size write while items are in flight
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> (!valid_s1 && !out_valid_q))
		else $error("size write with items in flight");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for byte_ring_buffer, with a queue-fed driver,
// a checking monitor and an operation-level ring model. Depends on brb_pkg and the RTL.
module tb_top;

	// mode codes the block leaves unused
	localparam logic [brb_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
	localparam logic [brb_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned GAP_MAX = 18;

	typedef struct {
		logic [brb_pkg::MODE_W-1:0] mode;
		logic [brb_pkg::DATA_W-1:0] data;
		logic [brb_pkg::OFS_W-1:0]  ofs;
		int unsigned                gap;
	} ring_op_t;

	typedef struct packed {
		logic [brb_pkg::DATA_W-1:0] rd;
		logic                       ok;
		logic [brb_pkg::CNT_W-1:0]  fill;
		logic [brb_pkg::CNT_W-1:0]  free;
	} ring_status_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [brb_pkg::CFG_W-1:0]    buffer_size = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [brb_pkg::MODE_W-1:0]   mode = '0;
	logic [brb_pkg::DATA_W-1:0]   data_in = '0;
	logic [brb_pkg::OFS_W-1:0]    offset = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [brb_pkg::DATA_W-1:0]   read_data;
	logic                         accepted;
	logic [brb_pkg::CNT_W-1:0]    fill_count;
	logic [brb_pkg::CNT_W-1:0]    free_count;

	// ring model state
	logic [brb_pkg::DATA_W-1:0]   ring_mem [brb_pkg::DEPTH_DEFAULT];
	int unsigned                  head_ptr = 0;
	int unsigned                  tail_ptr = 0;
	logic [brb_pkg::CFG_W-1:0]    size_reg = brb_pkg::CFG_W'(brb_pkg::SIZE_RESET);

	ring_op_t            pending_ops[$];
	ring_status_t        expected_status[$];
	ring_op_t            cur_op;
	int unsigned         ops_queued = 0;
	int unsigned         results_seen = 0;
	int unsigned         err_cnt = 0;
	int unsigned         gap_cnt = 0;
	int unsigned         stall_left = 0;
	int unsigned         rx_draw;
	int unsigned         quiet_cycles = 0;
	bit                  tx_quiet = 1'b0;
	bit                  rx_quiet = 1'b0;

	byte_ring_buffer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.buffer_size(buffer_size),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.data_in    (data_in),
		.offset     (offset),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.accepted   (accepted),
		.fill_count (fill_count),
		.free_count (free_count)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// register value to number of slots actually used
	function automatic int unsigned clamp_slots(input logic [brb_pkg::CFG_W-1:0] v);
		if (32'(v) < brb_pkg::SIZE_MIN) return brb_pkg::SIZE_MIN;
		if (32'(v) > brb_pkg::DEPTH_DEFAULT) return brb_pkg::DEPTH_DEFAULT;
		return 32'(v);
	endfunction

	function automatic int unsigned ring_wrap(input int unsigned a, input int unsigned b,
			input int unsigned slots);
		int unsigned r;
		r = a + b;
		if (r >= slots) r -= slots;
		return r;
	endfunction

	function automatic int unsigned ring_fill(input int unsigned slots);
		if (tail_ptr >= head_ptr) return tail_ptr - head_ptr;
		return slots - head_ptr + tail_ptr;
	endfunction

	// apply one operation to the ring model and return its status
	function automatic ring_status_t ring_apply(input ring_op_t op);
		int unsigned slots;
		int unsigned fill;
		int unsigned ofs;
		ring_status_t r;
		slots = clamp_slots(size_reg);
		fill = ring_fill(slots);
		ofs = 32'(op.ofs);
		r = '0;
		case (op.mode)
			brb_pkg::MODE_PUSH: begin
				if (fill < slots - 1) begin
					ring_mem[tail_ptr] = op.data;
					tail_ptr = ring_wrap(tail_ptr, 1, slots);
					r.ok = 1'b1;
				end
			end
			brb_pkg::MODE_POP: begin
				if (fill > 0) begin
					r.rd = ring_mem[head_ptr];
					head_ptr = ring_wrap(head_ptr, 1, slots);
					r.ok = 1'b1;
				end
			end
			brb_pkg::MODE_PEEK: begin
				if (ofs < fill) begin
					r.rd = ring_mem[ring_wrap(head_ptr, ofs, slots)];
					r.ok = 1'b1;
				end
			end
			brb_pkg::MODE_ADVANCE: begin
				if (ofs <= fill) begin
					head_ptr = ring_wrap(head_ptr, ofs, slots);
					r.ok = 1'b1;
				end
			end
			brb_pkg::MODE_OVERWRITE: begin
				if (ofs < fill) begin
					ring_mem[ring_wrap(head_ptr, ofs, slots)] = op.data;
					r.ok = 1'b1;
				end
			end
			brb_pkg::MODE_CLEAR: begin
				head_ptr = 0;
				tail_ptr = 0;
				r.ok = 1'b1;
			end
			default: begin
			end
		endcase
		fill = ring_fill(slots);
		r.fill = brb_pkg::CNT_W'(fill);
		r.free = brb_pkg::CNT_W'(slots - 1 - fill);
		return r;
	endfunction

	// queue one operation with its leading idle gap
	task automatic add_op(input logic [brb_pkg::MODE_W-1:0] m,
			input logic [brb_pkg::DATA_W-1:0] d, input logic [brb_pkg::OFS_W-1:0] o);
		ring_op_t op;
		if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
		op.mode = m;
		op.data = d;
		op.ofs = o;
		op.gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
		pending_ops.push_back(op);
		ops_queued++;
	endtask

	// random operations, push share set by push_pct
	task automatic add_random(input int unsigned count, input int unsigned slots,
			input int unsigned push_pct);
		int unsigned k;
		logic [brb_pkg::MODE_W-1:0] m;
		logic [brb_pkg::OFS_W-1:0] o;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < push_pct) begin
				m = brb_pkg::MODE_PUSH;
			end else begin
				k = $urandom_range(0, 19);
				if (k < 6) m = brb_pkg::MODE_POP;
				else if (k < 10) m = brb_pkg::MODE_PEEK;
				else if (k < 13) m = brb_pkg::MODE_ADVANCE;
				else if (k < 17) m = brb_pkg::MODE_OVERWRITE;
				else if (k == 17) m = brb_pkg::MODE_CLEAR;
				else if (k == 18) m = MODE_RSVD6;
				else m = MODE_RSVD7;
			end
			if ($urandom_range(0, 7) == 0) o = brb_pkg::OFS_W'($urandom_range(0, 1023));
			else o = brb_pkg::OFS_W'($urandom_range(0, slots));
			add_op(m, brb_pkg::DATA_W'($urandom_range(0, 255)), o);
		end
	endtask

	// block until every queued operation has produced its result
	task automatic wait_drain();
		do @(posedge clk); while (results_seen < ops_queued || expected_status.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// size register write, also empties the ring
	task automatic write_size(input logic [brb_pkg::CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		buffer_size <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = v;
		head_ptr = 0;
		tail_ptr = 0;
	endtask

	// input driver: one transaction per queued operation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= '0;
			data_in <= '0;
			offset <= '0;
			gap_cnt <= 0;
		end else begin
			if (in_valid && !in_stall) expected_status.push_back(ring_apply(cur_op));
			if (in_valid && in_stall) begin
				// payload held while stalled
			end else if (pending_ops.size() != 0 && gap_cnt >= pending_ops[0].gap) begin
				cur_op = pending_ops.pop_front();
				in_valid <= 1'b1;
				mode <= cur_op.mode;
				data_in <= cur_op.data;
				offset <= cur_op.ofs;
				gap_cnt <= 0;
			end else begin
				in_valid <= 1'b0;
				if (pending_ops.size() != 0) gap_cnt <= gap_cnt + 1;
			end
		end
	end

	task automatic check_field(input string name, input logic [brb_pkg::CNT_W-1:0] want,
			input logic [brb_pkg::CNT_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// output monitor: compare each result transaction, then draw a stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			results_seen++;
			if (expected_status.size() == 0) begin
				$display("%0t: unexpected result, expected none, got rd=%0d ok=%0b fill=%0d free=%0d",
					$time, read_data, accepted, fill_count, free_count);
				err_cnt++;
			end else begin
				check_field("read_data", brb_pkg::CNT_W'(expected_status[0].rd),
					brb_pkg::CNT_W'(read_data));
				check_field("accepted", brb_pkg::CNT_W'(expected_status[0].ok),
					brb_pkg::CNT_W'(accepted));
				check_field("fill_count", expected_status[0].fill, fill_count);
				check_field("free_count", expected_status[0].free, free_count);
				void'(expected_status.pop_front());
			end
			if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
			rx_draw = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
			stall_left <= rx_draw;
			out_stall <= (rx_draw != 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end
	end

	// cycles since the last transaction on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// watchdog
	initial begin
		@(posedge arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// stimulus sequence
	initial begin
		logic [brb_pkg::CFG_W-1:0] sizes [10];
		int unsigned slots;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed checks at the reset size
		add_op(brb_pkg::MODE_POP, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_PEEK, 8'hFF, 10'd0);
		add_op(brb_pkg::MODE_ADVANCE, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_ADVANCE, 8'h00, 10'd1);
		add_op(brb_pkg::MODE_OVERWRITE, 8'hFF, 10'd0);
		add_op(MODE_RSVD6, 8'hFF, 10'd1023);
		add_op(MODE_RSVD7, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_PUSH, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_PUSH, 8'hFF, 10'd1023);
		add_op(brb_pkg::MODE_PUSH, 8'h5A, 10'd0);
		add_op(brb_pkg::MODE_PEEK, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_PEEK, 8'h00, 10'd2);
		add_op(brb_pkg::MODE_PEEK, 8'h00, 10'd3);
		add_op(brb_pkg::MODE_PEEK, 8'h00, 10'd1023);
		add_op(brb_pkg::MODE_OVERWRITE, 8'hA5, 10'd1);
		add_op(brb_pkg::MODE_OVERWRITE, 8'hFF, 10'd3);
		add_op(brb_pkg::MODE_PEEK, 8'h00, 10'd1);
		add_op(brb_pkg::MODE_ADVANCE, 8'h00, 10'd1023);
		add_op(brb_pkg::MODE_ADVANCE, 8'h00, 10'd1);
		add_op(brb_pkg::MODE_POP, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_POP, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_POP, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_PUSH, 8'h3C, 10'd0);
		add_op(brb_pkg::MODE_CLEAR, 8'h00, 10'd0);
		add_op(brb_pkg::MODE_POP, 8'h00, 10'd0);
		wait_drain();

		// small sizes, including the clamped ones below the minimum
		sizes = '{11'd2, 11'd0, 11'd1, 11'd3, 11'd8, 11'd31, 11'd64,
			brb_pkg::CFG_W'($urandom_range(4, 48)), brb_pkg::CFG_W'($urandom_range(4, 48)),
			brb_pkg::CFG_W'($urandom_range(4, 48))};
		foreach (sizes[i]) begin
			write_size(sizes[i]);
			slots = clamp_slots(sizes[i]);
			add_random(25, slots, 65);
			wait_drain();
			add_random(25, slots, 30);
			wait_drain();
		end

		// all-ones size acts as full depth: deep fill, far offsets, advance
		write_size(11'h7FF);
		for (int i = 0; i < 200; i++)
			add_op(brb_pkg::MODE_PUSH, brb_pkg::DATA_W'($urandom_range(0, 255)),
				brb_pkg::OFS_W'($urandom_range(0, 1023)));
		add_op(brb_pkg::MODE_PEEK, 8'h00, 10'd199);
		add_op(brb_pkg::MODE_PEEK, 8'h00, 10'd200);
		for (int i = 0; i < 8; i++)
			add_op(brb_pkg::MODE_PEEK, 8'h00, brb_pkg::OFS_W'($urandom_range(0, 199)));
		add_op(brb_pkg::MODE_OVERWRITE, 8'h00, 10'd199);
		add_op(brb_pkg::MODE_OVERWRITE, 8'hFF, 10'd200);
		add_op(brb_pkg::MODE_PEEK, 8'h00, 10'd199);
		add_op(brb_pkg::MODE_ADVANCE, 8'h00, 10'd150);
		for (int i = 0; i < 10; i++)
			add_op(brb_pkg::MODE_PUSH, brb_pkg::DATA_W'($urandom_range(0, 255)), 10'd0);
		for (int i = 0; i < 6; i++)
			add_op(brb_pkg::MODE_PEEK, 8'h00, brb_pkg::OFS_W'($urandom_range(0, 32)));
		wait_drain();
		add_random(40, brb_pkg::DEPTH_DEFAULT, 40);
		wait_drain();

		// exact full depth and an oversized value
		write_size(11'd1024);
		add_random(30, brb_pkg::DEPTH_DEFAULT, 60);
		wait_drain();
		write_size(11'd1500);
		add_random(30, brb_pkg::DEPTH_DEFAULT, 50);
		wait_drain();

		repeat (4) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### byte_ring_buffer.f
hw/rtl/brb_pkg.sv
hw/rtl/brb_mem.sv
hw/rtl/brb_ctrl.sv
hw/rtl/byte_ring_buffer.sv
sim/tb_top.sv
